// ===== rtl/core/crlc_pkg.sv =====
// shared widths, codes and reciprocal constants for the clock ring led colour block
`timescale 1ns / 1ps
`default_nettype none

package crlc_pkg;

  // payload widths
  localparam int LED_W    = 7;
  localparam int MILLIS_W = 27;
  localparam int CHAN_W   = 8;
  localparam int MODE_W   = 2;
  localparam int MOOD_W   = 24;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // pipeline depth, input register to output register
  localparam int STAGES = 9;

  // register map, index = byte address / 4
  typedef enum logic [1:0] {
    REG_MODE       = 2'd0,
    REG_BRIGHTNESS = 2'd1,
    REG_MOOD       = 2'd2
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_BRIGHT = 2'd1,
    MODE_DARK   = 2'd2,
    MODE_MOOD   = 2'd3
  } mode_t;

  localparam logic [CHAN_W-1:0] BRIGHT_RESET = 8'd32;

  // ring layout
  localparam int HOUR_LEDS = 24;

  // floor(x / n) = (x * recip) >> shift over the ranges used here
  localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
  localparam int          SH10      = 35;
  localparam logic [31:0] RECIP100  = 32'h51EB_851F;
  localparam int          SH100     = 37;
  localparam logic [31:0] RECIP60   = 32'h8888_8889;
  localparam int          SH60      = 37;
  localparam logic [19:0] RECIP80   = 20'd838861;
  localparam int          SH80      = 26;
  localparam logic [7:0]  THIRD_MUL = 8'd171;
  localparam int          THIRD_SH  = 9;
  // 24 * centi / 10 and 24 * centi / 100 for centi below 100
  localparam logic [17:0] OFFH_MUL  = 18'd157296;
  localparam logic [13:0] RING_MUL  = 14'd15729;
  localparam int          FRAC_SH   = 16;

  localparam int CENTI_PER_SEC = 100;
  localparam int SEC_PER_MIN   = 60;

endpackage : crlc_pkg

`default_nettype wire

// ===== rtl/core/crlc_if.sv =====
// valid/ready channel interfaces for led requests and colour results
`timescale 1ns / 1ps
`default_nettype none

interface crlc_req_if
  import crlc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [LED_W-1:0]    led_index;
  logic [MILLIS_W-1:0] raw_millis;

  modport source (output valid, output led_index, output raw_millis, input ready);
  modport sink (input valid, input led_index, input raw_millis, output ready);
endinterface : crlc_req_if

interface crlc_rsp_if
  import crlc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface : crlc_rsp_if

`default_nettype wire

// ===== rtl/core/clock_ring_led_color.sv =====
// top level: per-led colour pipeline of the clock ring with its apb register block
// Computes the colour of one LED of a clock face (hour ring LEDs 0-23, minute ring
// LEDs 24-83) from the LED number and the time of day in milliseconds. The block keeps
// no state besides its three registers (mode, brightness_level, mood_color at byte
// addresses 0, 4 and 8), so every request is independent: one transfer can enter in
// every clock cycle when the result side never stalls. The nine register stages are set
// by the chain of constant-reciprocal multipliers that split the time into centiseconds,
// seconds, minutes and hour, and by the two multiplies that scale the hue wheel. Each
// stage holds its own valid bit and takes new data whenever it is empty or its successor
// moves, so a stall on the result side fills the bubbles first and only then holds off
// requests. There is no start-up pass after reset. Registers should be written only while
// nothing is in flight.
`timescale 1ns / 1ps
`default_nettype none

module clock_ring_led_color
  import crlc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // apb register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  // request and result channels
  crlc_req_if.sink                req,
  crlc_rsp_if.source              rsp
);

  // flags that ride along with one led through the colour stages
  typedef struct packed {
    logic       hour;     // led on the hour ring
    logic       mark;     // hour or minute hand lands here
    logic       led0;     // first minute led
    logic       sec_hit;  // minute led of the current second
    logic [4:0] ring_pos; // rotating position on the hour ring
  } led_tag_t;

  typedef enum logic [1:0] {
    SEG_RB,
    SEG_GB,
    SEG_RG
  } hue_seg_t;

  localparam int P10_W  = MILLIS_W + 32;
  localparam int Q10_W  = 24;
  localparam int P100_W = Q10_W + 32;
  localparam int Q100_W = 18;
  localparam int P60A_W = Q100_W + 32;
  localparam int Q60_W  = 12;
  localparam int P60B_W = Q60_W + 32;
  localparam int QH_W   = 6;
  localparam int HUE_W  = 15;
  localparam int P80_W  = HUE_W + 20;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  mode_t             mode;
  logic [CHAN_W-1:0] brightness_level;
  logic [MOOD_W-1:0] mood_color;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_PLAIN;
      brightness_level <= BRIGHT_RESET;
      mood_color       <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_MODE:       mode             <= mode_t'(pwdata[MODE_W-1:0]);
        REG_BRIGHTNESS: brightness_level <= pwdata[CHAN_W-1:0];
        REG_MOOD:       mood_color       <= pwdata[MOOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:       prdata = PDATA_W'(mode);
      REG_BRIGHTNESS: prdata = PDATA_W'(brightness_level);
      REG_MOOD:       prdata = PDATA_W'(mood_color);
      default:        prdata = '0;
    endcase
  end

  // brightness / 3, shared by the hue level and the dim layer
  logic [15:0] br3_prod;
  logic [6:0]  br3;

  assign br3_prod = 16'(brightness_level) * 16'(THIRD_MUL);
  assign br3      = br3_prod[THIRD_SH+6:THIRD_SH];

  // ------------------------------------------------------------------
  // stage handshake: a stage loads when it is empty or its successor moves
  // ------------------------------------------------------------------
  logic [STAGES:1]   v;
  logic [STAGES+1:1] rdy;
  logic [STAGES:1]   v_in;

  always_comb begin
    rdy[STAGES+1] = rsp.ready;
    for (int k = STAGES; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign v_in      = {v[STAGES-1:1], req.valid};
  assign req.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (rdy[STAGES:1] & v_in) | (~rdy[STAGES:1] & v);
    end
  end

  // ------------------------------------------------------------------
  // stages 1-5: split the time of day
  // ------------------------------------------------------------------
  logic [LED_W-1:0]  s1_d, s2_d, s3_d, s4_d, s5_d;
  logic [Q10_W-1:0]  s1_q10, s2_q10;
  logic [Q100_W-1:0] s2_q100, s3_q100;
  logic [6:0]        s3_centi;
  logic [Q60_W-1:0]  s3_q60, s4_q60;
  logic [5:0]        s4_sec, s5_sec;
  logic [QH_W-1:0]   s4_qh;
  logic [7:0]        s4_offh, s5_offh;
  logic [4:0]        s4_c24, s5_c24;
  logic [5:0]        s5_mins;
  logic [3:0]        s5_hr;

  logic [P10_W-1:0]  prod10;
  logic [P100_W-1:0] prod100;
  logic [Q10_W-1:0]  centi_full;
  logic [P60A_W-1:0] prod60a;
  logic [Q100_W-1:0] sec_full;
  logic [P60B_W-1:0] prod60b;
  logic [24:0]       offh_prod;
  logic [20:0]       c24_prod;
  logic [Q60_W-1:0]  mins_full;
  logic [3:0]        hr_next;

  // milliseconds to tens of milliseconds
  assign prod10 = P10_W'(req.raw_millis) * P10_W'(RECIP10);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_d   <= req.led_index;
      s1_q10 <= prod10[SH10+Q10_W-1:SH10];
    end
  end

  // tens of milliseconds to whole seconds
  assign prod100 = P100_W'(s1_q10) * P100_W'(RECIP100);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_d    <= s1_d;
      s2_q10  <= s1_q10;
      s2_q100 <= prod100[SH100+Q100_W-1:SH100];
    end
  end

  // centiseconds as remainder, seconds to minutes
  assign centi_full = s2_q10 - Q10_W'(s2_q100) * Q10_W'(CENTI_PER_SEC);
  assign prod60a    = P60A_W'(s2_q100) * P60A_W'(RECIP60);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_d     <= s2_d;
      s3_centi <= centi_full[6:0];
      s3_q100  <= s2_q100;
      s3_q60   <= prod60a[SH60+Q60_W-1:SH60];
    end
  end

  // seconds as remainder, minutes to hours, centisecond derived offsets
  assign sec_full  = s3_q100 - Q100_W'(s3_q60) * Q100_W'(SEC_PER_MIN);
  assign prod60b   = P60B_W'(s3_q60) * P60B_W'(RECIP60);
  assign offh_prod = 25'(s3_centi) * 25'(OFFH_MUL);
  assign c24_prod  = 21'(s3_centi) * 21'(RING_MUL);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_d    <= s3_d;
      s4_sec  <= sec_full[5:0];
      s4_q60  <= s3_q60;
      s4_qh   <= prod60b[SH60+QH_W-1:SH60];
      s4_offh <= offh_prod[FRAC_SH+7:FRAC_SH];
      s4_c24  <= c24_prod[FRAC_SH+4:FRAC_SH];
    end
  end

  // minutes as remainder, hour folded onto the twelve hour dial
  assign mins_full = s4_q60 - Q60_W'(s4_qh) * Q60_W'(SEC_PER_MIN);

  always_comb begin
    if (s4_qh >= 6'd36) begin
      hr_next = 4'(s4_qh - 6'd36);
    end else if (s4_qh >= 6'd24) begin
      hr_next = 4'(s4_qh - 6'd24);
    end else if (s4_qh >= 6'd12) begin
      hr_next = 4'(s4_qh - 6'd12);
    end else begin
      hr_next = s4_qh[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_d    <= s4_d;
      s5_sec  <= s4_sec;
      s5_mins <= mins_full[5:0];
      s5_hr   <= hr_next;
      s5_offh <= s4_offh;
      s5_c24  <= s4_c24;
    end
  end

  // ------------------------------------------------------------------
  // stage 6: led classification and hue wheel position
  // ------------------------------------------------------------------
  led_tag_t    s6_tag, tag_next;
  logic [7:0]  s6_p, s6_lvl;
  logic [6:0]  ring_idx;
  logic [5:0]  hsum;
  logic [4:0]  hpos;
  logic [3:0]  hnum;
  logic [7:0]  pos, off;
  logic [8:0]  wsum;
  logic [7:0]  p_next;
  logic [5:0]  isum;

  assign ring_idx = s5_d - LED_W'(HOUR_LEDS);
  // hour mark: ((d + 1) / 2) mod 12
  assign hsum     = 6'(s5_d[4:0]) + 6'd1;
  assign hpos     = hsum[5:1];
  assign hnum     = (hpos == 5'd12) ? 4'd0 : hpos[3:0];

  always_comb begin
    tag_next.hour    = s5_d < LED_W'(HOUR_LEDS);
    tag_next.mark    = tag_next.hour ? (hnum == s5_hr) : (ring_idx == 7'(s5_mins));
    tag_next.led0    = s5_d == LED_W'(HOUR_LEDS);
    tag_next.sec_hit = ring_idx == 7'(s5_sec);
    // rotating ring position, (24 + d - 24 * centi / 100) mod 24
    isum = 6'd24 + 6'(s5_d[4:0]) - 6'(s5_c24);
    tag_next.ring_pos = (isum >= 6'd24) ? 5'(isum - 6'd24) : isum[4:0];
  end

  // wheel position: hour leds step by 10, minute leds by 4 (kept to 8 bits)
  assign pos  = tag_next.hour ? 8'(s5_d) * 8'd10 : {ring_idx[5:0], 2'b00};
  assign off  = tag_next.hour ? s5_offh : {s5_sec, 2'b00};
  assign wsum = 9'd240 + 9'(pos) - 9'(off);

  always_comb begin
    if (wsum >= 9'd480) begin
      p_next = 8'(wsum - 9'd480);
    end else if (wsum >= 9'd240) begin
      p_next = 8'(wsum - 9'd240);
    end else begin
      p_next = wsum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_tag <= tag_next;
      s6_p   <= p_next;
      s6_lvl <= tag_next.led0 ? brightness_level : {1'b0, br3};
    end
  end

  // ------------------------------------------------------------------
  // stage 7: level times wheel coefficients
  // ------------------------------------------------------------------
  led_tag_t         s7_tag;
  hue_seg_t         s7_seg, seg_next;
  logic [HUE_W-1:0] s7_c1, s7_c2;
  logic [6:0]       coef_a, coef_b;

  always_comb begin
    if (s6_p < 8'd80) begin
      seg_next = SEG_RB;
      coef_a   = 7'(8'd80 - s6_p);
      coef_b   = s6_p[6:0];
    end else if (s6_p < 8'd160) begin
      seg_next = SEG_GB;
      coef_a   = 7'(s6_p - 8'd80);
      coef_b   = 7'(8'd160 - s6_p);
    end else begin
      seg_next = SEG_RG;
      coef_a   = 7'(s6_p - 8'd160);
      coef_b   = 7'(8'd240 - s6_p);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_tag <= s6_tag;
      s7_seg <= seg_next;
      s7_c1  <= HUE_W'(s6_lvl) * HUE_W'(coef_a);
      s7_c2  <= HUE_W'(s6_lvl) * HUE_W'(coef_b);
    end
  end

  // ------------------------------------------------------------------
  // stage 8: divide by the 80-step segment length, place on channels
  // ------------------------------------------------------------------
  led_tag_t          s8_tag;
  logic [CHAN_W-1:0] s8_hr, s8_hg, s8_hb;
  logic [P80_W-1:0]  prod80a, prod80b;
  logic [CHAN_W-1:0] h1, h2;

  assign prod80a = P80_W'(s7_c1) * P80_W'(RECIP80);
  assign prod80b = P80_W'(s7_c2) * P80_W'(RECIP80);
  assign h1      = prod80a[SH80+CHAN_W-1:SH80];
  assign h2      = prod80b[SH80+CHAN_W-1:SH80];

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_tag <= s7_tag;
      case (s7_seg)
        SEG_RB: begin
          s8_hr <= h1;
          s8_hg <= '0;
          s8_hb <= h2;
        end
        SEG_GB: begin
          s8_hr <= '0;
          s8_hg <= h1;
          s8_hb <= h2;
        end
        SEG_RG: begin
          s8_hr <= h1;
          s8_hg <= h2;
          s8_hb <= '0;
        end
        default: begin
          s8_hr <= '0;
          s8_hg <= '0;
          s8_hb <= '0;
        end
      endcase
    end
  end

  // ------------------------------------------------------------------
  // stage 9: pattern selection, dim layer, mood overlay; output register
  // ------------------------------------------------------------------
  logic [CHAN_W-1:0] s9_r, s9_g, s9_b;
  logic [CHAN_W-1:0] out_r, out_g, out_b;

  always_comb begin : colour
    logic [CHAN_W-1:0] b_r, b_g, b_b;
    logic [CHAN_W-1:0] dk_r, dk_g, dk_b;
    logic [CHAN_W-1:0] dim, grey;
    logic [2:0]        k;
    logic [5:0]        k6, i6;
    logic [8:0]        sum_r, sum_g, sum_b;

    // bright pattern above brightness 6: hands in white, the rest on the hue wheel
    b_r = '0;
    b_g = '0;
    b_b = '0;
    if (brightness_level > 8'd6) begin
      if (s8_tag.mark) begin
        b_r = brightness_level;
        b_g = brightness_level;
        b_b = brightness_level;
      end else begin
        b_r = s8_hr;
        b_g = s8_hg;
        b_b = s8_hb;
      end
    end

    // dim red layer at low brightness, with a short tail sweeping the hour ring
    k    = 3'(3'd4 - br3[2:0]);
    k6   = 6'(k);
    i6   = 6'(s8_tag.ring_pos);
    grey = (brightness_level > 8'd4) ? brightness_level : 8'd4;
    dim  = 8'd1;
    if (s8_tag.hour) begin
      if (i6 < k6) begin
        dim = 8'(k6 - i6);
      end else if (i6 > 6'd21 + k6) begin
        dim = 8'(i6 - (6'd20 + k6));
      end
    end else if (s8_tag.led0) begin
      dim = 8'd2;
    end else if (s8_tag.sec_hit) begin
      dim = 8'd6;
    end
    if (brightness_level < 8'd12) begin
      if (s8_tag.mark) begin
        b_r = grey;
        b_g = grey;
        b_b = grey;
      end else if (dim > b_r) begin
        b_r = dim;
      end
    end

    // dark pattern: fixed dim values
    dk_r = 8'd1;
    dk_g = '0;
    dk_b = '0;
    if (s8_tag.mark) begin
      dk_r = 8'd4;
      dk_g = 8'd4;
      dk_b = 8'd4;
    end else if (s8_tag.hour) begin
      if (s8_tag.ring_pos < 5'd3) begin
        dk_r = 8'(5'd4 - s8_tag.ring_pos);
      end else if (s8_tag.ring_pos > 5'd21) begin
        dk_r = 8'(s8_tag.ring_pos - 5'd20);
      end
    end else if (s8_tag.led0) begin
      dk_r = 8'd2;
    end else if (s8_tag.sec_hit) begin
      dk_r = 8'd6;
    end

    // mood overlay, saturating per channel
    sum_r = 9'(b_r) + 9'(mood_color[23:16]);
    sum_g = 9'(b_g) + 9'(mood_color[15:8]);
    sum_b = 9'(b_b) + 9'(mood_color[7:0]);

    case (mode)
      MODE_PLAIN: begin
        out_r = '0;
        out_g = s8_tag.mark ? brightness_level : '0;
        out_b = '0;
      end
      MODE_BRIGHT: begin
        out_r = b_r;
        out_g = b_g;
        out_b = b_b;
      end
      MODE_DARK: begin
        out_r = dk_r;
        out_g = dk_g;
        out_b = dk_b;
      end
      MODE_MOOD: begin
        out_r = sum_r[8] ? 8'hFF : sum_r[7:0];
        out_g = sum_g[8] ? 8'hFF : sum_g[7:0];
        out_b = sum_b[8] ? 8'hFF : sum_b[7:0];
      end
      default: begin
        out_r = '0;
        out_g = '0;
        out_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_r <= out_r;
      s9_g <= out_g;
      s9_b <= out_b;
    end
  end

  assign rsp.valid = v[STAGES];
  assign rsp.red   = s9_r;
  assign rsp.green = s9_g;
  assign rsp.blue  = s9_b;

`ifndef SYNTHESIS
  // time split stays inside its field ranges
  a_time_fields: assert property (@(posedge clk) disable iff (rst)
    v[5] |-> (s5_sec < 6'd60) && (s5_mins < 6'd60) && (s5_hr < 4'd12))
    else $error("time split out of range");

  // plain pattern only ever lights green
  a_plain_green: assert property (@(posedge clk) disable iff (rst)
    rdy[9] && v[8] && (mode == MODE_PLAIN) |=> (s9_r == '0) && (s9_b == '0))
    else $error("plain pattern lit red or blue");

  // dark pattern stays at its fixed dim levels
  a_dark_levels: assert property (@(posedge clk) disable iff (rst)
    rdy[9] && v[8] && (mode == MODE_DARK)
      |=> (s9_r <= 8'd6) && (s9_g <= 8'd4) && (s9_b <= 8'd4))
    else $error("dark pattern too bright");
`endif

endmodule : clock_ring_led_color

`default_nettype wire

// ===== dv/clock_ring_led_color_tb.sv =====
// self-checking testbench for the clock ring led colour block: directed table, then random phases
`timescale 1ns / 1ps

module clock_ring_led_color_tb;
  import crlc_pkg::*;

  // colour of one led, red in the top byte
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } colour_t;

  // clock fields taken from the millisecond count
  typedef struct packed {
    int unsigned centi;
    int unsigned sec;
    int unsigned mins;
    int unsigned hr;
  } tod_t;

  // one directed transfer, with the register setting it runs under
  typedef struct packed {
    mode_t               md;
    logic [CHAN_W-1:0]   br;
    logic [MOOD_W-1:0]   mood;
    logic [LED_W-1:0]    led;
    logic [MILLIS_W-1:0] ms;
    bit                  typed;
    colour_t             want;
  } dir_row_t;

  localparam int CYCLE_LIMIT = 300000;
  localparam int N_DIR       = 25;
  localparam int N_PHASES    = 23;
  localparam int PHASE_ITEMS = 50;
  localparam int HOLD_CYCLES = 300;
  localparam int DAY_MS_MAX  = 86399999;

  // the directed table: typed colours only where they follow at a glance
  dir_row_t dir_rows [N_DIR] = '{
    // reset setting: plain, brightness 32, no mood
    '{MODE_PLAIN,  8'd32,  24'h000000, 7'd0,   27'd0,        1'b1, 24'h002000},
    '{MODE_PLAIN,  8'd32,  24'h000000, 7'd1,   27'd0,        1'b1, 24'h000000},
    '{MODE_PLAIN,  8'd32,  24'h000000, 7'd24,  27'd0,        1'b1, 24'h002000},
    '{MODE_PLAIN,  8'd32,  24'h000000, 7'd83,  27'd86399999, 1'b1, 24'h002000},
    '{MODE_PLAIN,  8'd32,  24'h000000, 7'd22,  27'd86399999, 1'b1, 24'h002000},
    // led beyond the minute ring, time beyond one day
    '{MODE_PLAIN,  8'd32,  24'h000000, 7'd127, 27'h7FFFFFF,  1'b1, 24'h000000},
    '{MODE_PLAIN,  8'd255, 24'h000000, 7'd23,  27'd0,        1'b1, 24'h00FF00},
    '{MODE_PLAIN,  8'd0,   24'h000000, 7'd0,   27'd0,        1'b1, 24'h000000},
    '{MODE_BRIGHT, 8'd255, 24'h000000, 7'd0,   27'd0,        1'b1, 24'hFFFFFF},
    '{MODE_BRIGHT, 8'd255, 24'h000000, 7'd5,   27'd12345678, 1'b0, 24'h000000},
    '{MODE_BRIGHT, 8'd255, 24'h000000, 7'd24,  27'd3599999,  1'b0, 24'h000000},
    '{MODE_BRIGHT, 8'd255, 24'h000000, 7'd100, 27'd0,        1'b0, 24'h000000},
    // both the hue and the dim layer
    '{MODE_BRIGHT, 8'd7,   24'h000000, 7'd3,   27'd999,      1'b0, 24'h000000},
    '{MODE_BRIGHT, 8'd11,  24'h000000, 7'd24,  27'd0,        1'b1, 24'h0B0B0B},
    '{MODE_BRIGHT, 8'd0,   24'h000000, 7'd0,   27'd0,        1'b1, 24'h040404},
    '{MODE_BRIGHT, 8'd0,   24'h000000, 7'd30,  27'd6000,     1'b1, 24'h060000},
    '{MODE_BRIGHT, 8'd0,   24'h000000, 7'd12,  27'd500,      1'b0, 24'h000000},
    '{MODE_DARK,   8'd32,  24'h000000, 7'd0,   27'd0,        1'b1, 24'h040404},
    '{MODE_DARK,   8'd32,  24'h000000, 7'd24,  27'd60000,    1'b1, 24'h020000},
    '{MODE_DARK,   8'd32,  24'h000000, 7'd59,  27'd35000,    1'b1, 24'h060000},
    '{MODE_DARK,   8'd32,  24'h000000, 7'd7,   27'h7FFFFFF,  1'b0, 24'h000000},
    '{MODE_DARK,   8'd32,  24'h000000, 7'd40,  27'd0,        1'b1, 24'h010000},
    // mood saturation at full scale
    '{MODE_MOOD,   8'd255, 24'hFFFFFF, 7'd9,   27'd4242424,  1'b1, 24'hFFFFFF},
    '{MODE_MOOD,   8'd0,   24'h000000, 7'd127, 27'd0,        1'b0, 24'h000000},
    '{MODE_MOOD,   8'd100, 24'h123456, 7'd15,  27'd50000000, 1'b0, 24'h000000}
  };

  bit clk = 1'b0;
  logic rst;

  // apb register port
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  crlc_req_if req_ch ();
  crlc_rsp_if rsp_ch ();

  // register values as the block should hold them
  mode_t             cur_mode = MODE_PLAIN;
  logic [CHAN_W-1:0] cur_br   = BRIGHT_RESET;
  logic [MOOD_W-1:0] cur_mood = '0;

  colour_t     pending_colours [$];
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  bit          valid_up    = 1'b0;
  bit          hold_req    = 1'b0;

  clock_ring_led_color i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // colour prediction
  // ---------------------------------------------------------------------------

  // centiseconds, seconds, minutes and hour modulo 12
  function automatic tod_t split_time(logic [MILLIS_W-1:0] ms);
    tod_t        f;
    int unsigned t;
    t = 32'(ms);
    t = t / 10;
    f.centi = t % 100;
    t = t / 100;
    f.sec = t % 60;
    t = t / 60;
    f.mins = t % 60;
    t = t / 60;
    f.hr = t % 12;
    return f;
  endfunction

  // 240-step hue wheel, both angles kept to 8 bits
  function automatic colour_t wheel_colour(int unsigned pos, int unsigned off, int unsigned lvl);
    int unsigned p;
    colour_t     c;
    p = (240 + (pos & 255) - (off & 255)) % 240;
    if (p < 80) begin
      c.red   = 8'(lvl * (80 - p) / 80);
      c.green = '0;
      c.blue  = 8'(lvl * p / 80);
    end else if (p < 160) begin
      c.red   = '0;
      c.green = 8'(lvl * (p - 80) / 80);
      c.blue  = 8'(lvl * (160 - p) / 80);
    end else begin
      c.red   = 8'(lvl * (p - 160) / 80);
      c.green = 8'(lvl * (240 - p) / 80);
      c.blue  = '0;
    end
    return c;
  endfunction

  function automatic logic [CHAN_W-1:0] sat8(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    int unsigned s;
    s = 32'(a) + 32'(b);
    return (s > 255) ? 8'd255 : 8'(s);
  endfunction

  function automatic colour_t led_colour(logic [LED_W-1:0] led, logic [MILLIS_W-1:0] ms,
                                         mode_t md, logic [CHAN_W-1:0] br_in,
                                         logic [MOOD_W-1:0] mood);
    tod_t        f;
    int unsigned d;
    int unsigned br;
    int unsigned i;
    int unsigned k;
    int unsigned r;
    bit          hour_ring;
    bit          mark;
    colour_t     c;
    f         = split_time(ms);
    d         = 32'(led);
    br        = 32'(br_in);
    hour_ring = (d < 24);
    mark      = hour_ring ? (((d + 1) / 2) % 12 == f.hr) : (d - 24 == f.mins);
    c         = '0;
    case (md)
      MODE_PLAIN: begin
        if (mark) c.green = br_in;
      end
      MODE_DARK: begin
        if (mark) begin
          c = {8'd4, 8'd4, 8'd4};
        end else if (hour_ring) begin
          // tail of red running round the hour ring once a second
          i = (24 + d - 24 * f.centi / 100) % 24;
          if (i < 3) c.red = 8'(4 - i);
          else if (i > 21) c.red = 8'(i - 20);
          else c.red = 8'd1;
        end else if (d == 24) begin
          c.red = 8'd2;
        end else if (d - 24 == f.sec) begin
          c.red = 8'd6;
        end else begin
          c.red = 8'd1;
        end
      end
      default: begin
        // bright and mood share the bright pattern
        if (br > 6) begin
          if (mark) c = {br_in, br_in, br_in};
          else if (hour_ring) c = wheel_colour(d * 10, 24 * f.centi / 10, br / 3);
          else if (d == 24) c = wheel_colour(0, 4 * f.sec, br);
          else c = wheel_colour((d - 24) * 4, 4 * f.sec, br / 3);
        end
        if (br < 12) begin
          // dim red layer on top of whatever the hue gave
          r = 32'(c.red);
          if (mark) begin
            k = (br > 4) ? br : 4;
            c = {8'(k), 8'(k), 8'(k)};
          end else begin
            if (hour_ring) begin
              i = (24 + d - 24 * f.centi / 100) % 24;
              k = 4 - br / 3;
              if (i < k) r = (k - i > r) ? k - i : r;
              else if (i > 21 + k) r = (i - (20 + k) > r) ? i - (20 + k) : r;
              else r = (r < 1) ? 1 : r;
            end else if (d == 24) begin
              r = (r < 2) ? 2 : r;
            end else if (d - 24 == f.sec) begin
              r = (r < 6) ? 6 : r;
            end else begin
              r = (r < 1) ? 1 : r;
            end
            c.red = 8'(r);
          end
        end
        if (md == MODE_MOOD) begin
          c.red   = sat8(c.red, mood[23:16]);
          c.green = sat8(c.green, mood[15:8]);
          c.blue  = sat8(c.blue, mood[7:0]);
        end
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // request side and register writes, all driven at the falling edge
  // ---------------------------------------------------------------------------

  // offer one request, hold it until the transfer, then maybe pause between bursts
  task automatic offer(logic [LED_W-1:0] led, logic [MILLIS_W-1:0] ms, bit typed,
                       colour_t want);
    int unsigned gap;
    req_ch.valid      <= 1'b1;
    req_ch.led_index  <= led;
    req_ch.raw_millis <= ms;
    valid_up = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    // the setting cannot change while requests are in flight, so predict now
    pending_colours.push_back(typed ? want : led_colour(led, ms, cur_mode, cur_br, cur_mood));
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // stop offering and wait until every predicted colour has come back
  task automatic settle();
    if (valid_up) begin
      req_ch.valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (pending_colours.size() != 0) @(negedge clk);
  endtask

  // setup cycle then access cycle; psel stays up across back-to-back writes
  task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  // write all three registers with the block idle; junk above the field must be dropped
  task automatic apply_config(mode_t md, logic [CHAN_W-1:0] br, logic [MOOD_W-1:0] mood,
                              bit junk);
    logic [PDATA_W-1:0] hi;
    settle();
    hi = junk ? $urandom : '0;
    reg_write(REG_MODE, {hi[31:MODE_W], md});
    reg_write(REG_BRIGHTNESS, {hi[31:CHAN_W], br});
    reg_write(REG_MOOD, {hi[31:MOOD_W], mood});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_mode = md;
    cur_br   = br;
    cur_mood = mood;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t          row;
    tod_t              f;
    mode_t             md;
    logic [CHAN_W-1:0] br;
    logic [MOOD_W-1:0] mood;
    logic [MILLIS_W-1:0] ms;
    logic [LED_W-1:0]  led;
    int unsigned       sel;

    // every input known from time zero
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_ch.valid      = 1'b0;
    req_ch.led_index  = '0;
    req_ch.raw_millis = '0;
    rsp_ch.ready      = 1'b0;

    // reset, released at a falling edge
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part; the first rows run on the reset values
    for (int n = 0; n < N_DIR; n++) begin
      row = dir_rows[n];
      if (row.md != cur_mode || row.br != cur_br || row.mood != cur_mood)
        apply_config(row.md, row.br, row.mood, 1'b0);
      offer(row.led, row.ms, row.typed, row.want);
    end

    // random part, one register setting per phase
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin md = MODE_PLAIN;  br = 8'd0;   mood = 24'h000000; end
        1: begin md = MODE_BRIGHT; br = 8'd255; mood = 24'h000000; end
        2: begin md = MODE_DARK;   br = 8'd0;   mood = 24'hFFFFFF; end
        3: begin md = MODE_MOOD;   br = 8'd255; mood = 24'hFFFFFF; end
        4: begin md = MODE_MOOD;   br = 8'd0;   mood = 24'h000000; end
        // either side of the dim-layer and hue thresholds
        5: begin md = MODE_BRIGHT; br = 8'd6;   mood = 24'h000000; end
        6: begin md = MODE_BRIGHT; br = 8'd7;   mood = 24'h000000; end
        7: begin md = MODE_BRIGHT; br = 8'd11;  mood = 24'h000000; end
        8: begin md = MODE_MOOD;   br = 8'd12;  mood = MOOD_W'($urandom); end
        default: begin
          md = mode_t'($urandom_range(0, 3));
          case ($urandom_range(0, 3))
            0:       br = CHAN_W'($urandom_range(0, 13));
            1:       br = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: br = CHAN_W'($urandom_range(0, 255));
          endcase
          case ($urandom_range(0, 3))
            0:       mood = 24'h000000;
            1:       mood = 24'hFFFFFF;
            default: mood = MOOD_W'($urandom);
          endcase
        end
      endcase
      apply_config(md, br, mood, ph >= 5);

      // long result-side hold while requests keep coming, so the pipe backs up
      if (ph == 9) hold_req = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly within one day, now and then the full 27-bit count
        ms = ($urandom_range(0, 6) == 0) ? MILLIS_W'($urandom)
                                         : MILLIS_W'($urandom_range(0, DAY_MS_MAX));
        f   = split_time(ms);
        sel = $urandom_range(0, 99);
        // aim at the marks, the second led and led 0 of the minute ring
        if (sel < 25) led = LED_W'($urandom_range(0, 83));
        else if (sel < 45) begin
          if (f.hr == 0) led = $urandom_range(0, 1) ? 7'd0 : 7'd23;
          else led = LED_W'(2 * f.hr - $urandom_range(0, 1));
        end
        else if (sel < 65) led = LED_W'(HOUR_LEDS + f.mins);
        else if (sel < 80) led = LED_W'(HOUR_LEDS + f.sec);
        else if (sel < 90) led = LED_W'(HOUR_LEDS);
        else led = LED_W'($urandom_range(84, 127));
        offer(led, ms, 1'b0, '0);
      end
    end

    settle();
    // a little tail to catch stray results
    repeat (2 * STAGES) @(posedge clk);
    if (err_count == 0 && pending_colours.size() == 0) begin
      $display("clock_ring_led_color_tb: clean");
    end else begin
      $display("clock_ring_led_color_tb: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: stall pattern, long hold, and checking
  // ---------------------------------------------------------------------------

  int unsigned seg_left  = 0;
  int unsigned seg_mode  = 0;
  int unsigned hold_left = 0;
  logic [15:0] stall_pat = '0;

  // segments of always-ready, a rotating stall pattern, or random stalls
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode  = $urandom_range(0, 2);
        seg_left  = $urandom_range(20, 120);
        stall_pat = 16'($urandom);
      end
      seg_left--;
      case (seg_mode)
        0: rsp_ch.ready <= 1'b1;
        1: begin
          rsp_ch.ready <= ~stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
        default: rsp_ch.ready <= ($urandom_range(0, 99) >= 35);
      endcase
    end
  end

  // compare each result transfer with the oldest predicted colour
  always @(posedge clk) begin
    colour_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_colours.size() == 0) begin
        $error("result transfer with no colour pending: %02h %02h %02h",
               rsp_ch.red, rsp_ch.green, rsp_ch.blue);
        err_count++;
      end else begin
        want = pending_colours.pop_front();
        if (rsp_ch.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, rsp_ch.red);
          err_count++;
        end
        if (rsp_ch.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, rsp_ch.green);
          err_count++;
        end
        if (rsp_ch.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, rsp_ch.blue);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("clock_ring_led_color_tb: errors");
      $finish;
    end
  end

endmodule : clock_ring_led_color_tb

// ===== clock_ring_led_color.f =====
rtl/core/crlc_pkg.sv
rtl/core/crlc_if.sv
rtl/core/clock_ring_led_color.sv
dv/clock_ring_led_color_tb.sv
